// ----- hdl/grcw_pkg.sv -----
// Package for the grid ray cell walker: job record, front-end states, widths.
// No dependencies; used by the front end, queue, back end and top level.
package grcw_pkg;

    localparam int CW         = 40;  // cell center accumulator width
    localparam int PW         = 72;  // crossing product accumulator width
    localparam int MAGW       = 33;  // |delta| width
    localparam int DIV_STEPS  = 32;
    localparam int MUL_STEPS  = 33;
    localparam int CNTW       = 6;
    localparam int QDEPTH     = 2;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] gx;
        logic signed [CW-1:0] gy;
        logic [PW-1:0]        p;
        logic [PW-1:0]        q;
        logic [PW-1:0]        sx;
        logic [PW-1:0]        sy;
        logic [30:0]          cs;
        logic                 dxpos;
        logic                 dypos;
        logic                 dxnz;
        logic                 dynz;
    } t_job;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SETUP = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_PUSH  = 5'b10000
    } t_fstate;

    function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
        logic [31:0] r;
        if (v > CW'(signed'(32'h7FFF_FFFF)))
            r = 32'h7FFF_FFFF;
        else if (v < CW'(signed'(32'h8000_0000)))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hdl/grcw_front.sv -----
// Front end: takes a segment, finds floor remainders by shift-subtract and the
// crossing products by shift-add, then pushes one job. Depends on grcw_pkg.
module grcw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [127:0]         i_data,
    input  logic [30:0]          i_cell_size,
    output logic                 o_push,
    output grcw_pkg::t_job       o_job,
    input  logic                 i_full
);
    import grcw_pkg::*;

    t_fstate          r_state;
    logic [CNTW-1:0]  r_cnt;
    logic [31:0]      r_x [4];
    logic [31:0]      r_a [4];
    logic [30:0]      r_rem [4];
    logic [30:0]      r_cs;
    t_job             r_job;
    logic [PW-1:0]    r_mnx, r_mny, r_mcs;
    logic [MAGW-1:0]  r_mady, r_madx;
    logic [31:0]      n_rem [4];
    logic [30:0]      fm [4];
    logic signed [MAGW-1:0] dx, dy;
    logic [MAGW-1:0]  adx, ady;
    logic [31:0]      nx, ny;
    logic [31:0]      t;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t = {r_rem[i], r_a[i][31]};
            n_rem[i] = (t >= {1'b0, r_cs}) ? t - {1'b0, r_cs} : t;
            fm[i] = (r_x[i][31] && r_rem[i] != '0) ? r_cs - r_rem[i] : r_rem[i];
        end
        dx  = MAGW'(signed'(r_x[2])) - MAGW'(signed'(r_x[0]));
        dy  = MAGW'(signed'(r_x[3])) - MAGW'(signed'(r_x[1]));
        adx = dx[MAGW-1] ? -dx : dx;
        ady = dy[MAGW-1] ? -dy : dy;
        nx  = (dx > 0) ? {1'b0, r_cs - fm[0]} : {1'b0, fm[0]};
        ny  = (dy > 0) ? {1'b0, r_cs - fm[1]} : {1'b0, fm[1]};
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_push  = (r_state == ST_PUSH) && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cs <= (i_cell_size == '0) ? 31'd1 : i_cell_size;
                        for (int i = 0; i < 4; i++) begin
                            r_x[i]   <= i_data[32*i +: 32];
                            r_a[i]   <= i_data[32*i+31] ? -i_data[32*i +: 32]
                                                        : i_data[32*i +: 32];
                            r_rem[i] <= '0;
                        end
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    for (int i = 0; i < 4; i++) begin
                        r_rem[i] <= n_rem[i][30:0];
                        r_a[i]   <= {r_a[i][30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(DIV_STEPS - 1))
                        r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_job.cx <= CW'(signed'(r_x[0])) - CW'(fm[0]) + CW'(r_cs >> 1);
                    r_job.cy <= CW'(signed'(r_x[1])) - CW'(fm[1]) + CW'(r_cs >> 1);
                    r_job.gx <= CW'(signed'(r_x[2])) - CW'(fm[2]) + CW'(r_cs >> 1);
                    r_job.gy <= CW'(signed'(r_x[3])) - CW'(fm[3]) + CW'(r_cs >> 1);
                    r_job.p  <= '0;
                    r_job.q  <= '0;
                    r_job.sx <= '0;
                    r_job.sy <= '0;
                    r_job.cs <= r_cs;
                    r_job.dxpos <= (dx > 0);
                    r_job.dypos <= (dy > 0);
                    r_job.dxnz  <= (dx != 0);
                    r_job.dynz  <= (dy != 0);
                    r_mnx  <= PW'(nx);
                    r_mny  <= PW'(ny);
                    r_mcs  <= PW'(r_cs);
                    r_mady <= ady;
                    r_madx <= adx;
                    r_cnt  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_mady[0]) begin
                        r_job.p  <= r_job.p + r_mnx;
                        r_job.sx <= r_job.sx + r_mcs;
                    end
                    if (r_madx[0]) begin
                        r_job.q  <= r_job.q + r_mny;
                        r_job.sy <= r_job.sy + r_mcs;
                    end
                    r_mnx  <= r_mnx << 1;
                    r_mny  <= r_mny << 1;
                    r_mcs  <= r_mcs << 1;
                    r_mady <= r_mady >> 1;
                    r_madx <= r_madx >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(MUL_STEPS - 1))
                        r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_full)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/grcw_queue.sv -----
// Two-entry job queue between front end and back end.
// Depends on grcw_pkg.
module grcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  grcw_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output grcw_pkg::t_job o_job
);
    import grcw_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_job            r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + 1'b1;
            if (i_pop)
                r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ----- hdl/grcw_back.sv -----
// Back end: walks cells one per cycle unless stalled, by add-and-compare of
// crossing products, drives the registered result beat. Depends on grcw_pkg.
module grcw_back #(
    parameter int MAX_CELLS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  grcw_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_data,
    output logic           o_last,
    output logic           o_trunc
);
    import grcw_pkg::*;

    localparam int NW = $clog2(MAX_CELLS + 1);

    logic          r_busy;
    t_job          r_job;
    logic [NW-1:0] r_n;
    logic          r_ovalid;
    logic [63:0]   r_odata;
    logic          r_olast, r_otrunc;
    logic          at_goal, full, fire, step_x;
    logic signed [CW-1:0] stx, sty;

    always_comb begin
        at_goal = (r_job.cx == r_job.gx) && (r_job.cy == r_job.gy);
        full    = ((NW+1)'(r_n) + 1'b1) >= (NW+1)'(MAX_CELLS);
        fire    = r_busy && (!r_ovalid || i_ready);
        step_x  = r_job.dxnz && (!r_job.dynz || r_job.p < r_job.q);
        stx     = r_job.dxpos ? CW'(r_job.cs) : -CW'(r_job.cs);
        sty     = r_job.dypos ? CW'(r_job.cs) : -CW'(r_job.cs);
    end

    assign o_pop   = !r_busy && !i_empty;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_trunc = r_otrunc;

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_job <= i_job;
        if (fire) begin
            r_odata  <= {sat32(r_job.cy), sat32(r_job.cx)};
            r_olast  <= at_goal || full;
            r_otrunc <= !at_goal && full;
            if (!(at_goal || full)) begin
                if (step_x) begin
                    r_job.p  <= r_job.p + r_job.sx;
                    r_job.cx <= r_job.cx + stx;
                end else begin
                    r_job.q  <= r_job.q + r_job.sy;
                    r_job.cy <= r_job.cy + sty;
                end
            end
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (fire) begin
                r_n <= r_n + 1'b1;
                if (at_goal || full)
                    r_busy <= 1'b0;
            end
            if (fire)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

endmodule

// ----- hdl/grid_ray_cell_walker.sv -----
// Top level of the grid ray cell walker: cell size register, front end,
// job queue and back end. Depends on grcw_pkg, grcw_front, grcw_queue, grcw_back.
//
//   channel   direction  handshake                 payload
//   s stream  in         i_s_tvalid / o_s_tready   i_s_tdata (segment)
//   m stream  out        o_m_tvalid / i_m_tready   o_m_tdata, o_m_tlast, o_m_tuser
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data (cell_size)
//
// Front end runs the remainder shift loop, then the product shift loop, for each
// segment; back end emits one cell a cycle unless the output stalls, up to MAX_CELLS.
// Queue holds two jobs, so front and back overlap across segments.
// Synchronous active-low reset clears control; cell_size resets to 1.0.
// A stalled output beat holds its payload; cfg is always ready.
module grid_ray_cell_walker #(
    parameter int MAX_CELLS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // start_x, start_y, end_x, end_y
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // center_x, center_y
    output logic         o_m_tlast,   // last_cell
    output logic         o_m_tuser,   // truncated
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data   // cell_size
);
    import grcw_pkg::*;

    logic [30:0] r_cell_size;
    logic        push, qfull, pop, qempty;
    t_job        fjob, qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cell_size <= 31'(64'd1 << FRAC_BITS);
        else if (i_cfg_valid)
            r_cell_size <= i_cfg_data;
    end

    grcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_data      (i_s_tdata),
        .i_cell_size (r_cell_size),
        .o_push      (push),
        .o_job       (fjob),
        .i_full      (qfull)
    );

    grcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fjob),
        .o_full  (qfull),
        .i_pop   (pop),
        .o_empty (qempty),
        .o_job   (qjob)
    );

    grcw_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (qempty),
        .i_job   (qjob),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_trunc (o_m_tuser)
    );

endmodule

// ----- hdl/grcw_checker.sv -----
// Port-level checks for grid_ray_cell_walker, bound to the top level.
// Depends only on the top level's ports.
module grcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("truncated beat without tlast");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output beat changed");

endmodule

bind grid_ray_cell_walker grcw_checker u_grcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
